FILE: rtl/granular_grain_oscillator_assert.svh
// Assertion macros for the grain oscillator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GRANULAR_GRAIN_OSCILLATOR_ASSERT_SVH
`define GRANULAR_GRAIN_OSCILLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GGO_ASSERT(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("ggo assertion failed");
`define GGO_ASSERT_NR(label, clock, prop) \
    label: assert property (@(posedge clock) prop) \
        else $error("ggo assertion failed");
`else
`define GGO_ASSERT(label, clock, resetn, prop)
`define GGO_ASSERT_NR(label, clock, prop)
`endif
`endif

FILE: rtl/ggo_pkg.sv
// Shared types and constants for the grain oscillator.
// No dependencies; used by every module in rtl/.
package ggo_pkg;

    localparam int GGO_MAX_GRAINS       = 8;
    localparam int GGO_SINE_POINTS      = 4096;
    localparam int GGO_MAX_OVERSAMPLE   = 8;
    localparam int GGO_PITCH_ROM_POINTS = 1024;

    localparam int MUL_W     = 33;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FUND_INC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_INC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OS_SHIFT = 3'd4;

    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam logic [31:0] LCG_SEED = 32'h9E3779B9;

    localparam logic [63:0]  HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]  LN2_Q30     = 64'd744261118;
    localparam logic [127:0] NORM_SQ     = 128'd6184752906;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLK_MUL,
        ST_CLK_ADD,
        ST_LCG1_MUL,
        ST_LCG1_W,
        ST_SS_MUL,
        ST_SS_W,
        ST_E_MUL,
        ST_E_W,
        ST_PITCH_RD,
        ST_INC_MUL,
        ST_INC_W,
        ST_LCG2_MUL,
        ST_LCG2_W,
        ST_GAIN_MUL,
        ST_GAIN_W,
        ST_FUND,
        ST_GRAIN,
        ST_WIN_RD,
        ST_WIN_MUL,
        ST_WIN_W,
        ST_WG_MUL,
        ST_WG_W,
        ST_SIN_MUL,
        ST_SIN_W,
        ST_TERM_MUL,
        ST_TERM_W,
        ST_NORM_MUL,
        ST_NORM_W,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/ggo_mult.sv
// Shared signed multiplier with registered product.
// Depends on ggo_pkg for the operand width.
module ggo_mult (
    input  logic                                clk,
    input  logic signed [ggo_pkg::MUL_W-1:0]    a,
    input  logic signed [ggo_pkg::MUL_W-1:0]    b,
    output logic signed [2*ggo_pkg::MUL_W-1:0]  p
);
    import ggo_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: rtl/ggo_sine_rom.sv
// Q1.15 sine table with SINE_POINTS+1 entries, two registered reads (i, i+1).
// Contents built at elaboration; depends on ggo_pkg.
module ggo_sine_rom #(
    parameter int SINE_POINTS = ggo_pkg::GGO_SINE_POINTS
) (
    input  logic                             clk,
    input  logic [$clog2(SINE_POINTS)-1:0]   addr,
    output logic signed [15:0]               lo,
    output logic signed [15:0]               hi
);
    import ggo_pkg::*;

    localparam int L = $clog2(SINE_POINTS);

    function automatic logic [63:0] series_div(logic [63:0] t, int i);
        case (i)
            0:       return t / 6;
            1:       return t / 20;
            2:       return t / 42;
            3:       return t / 72;
            4:       return t / 110;
            5:       return t / 156;
            default: return t / 210;
        endcase
    endfunction

    // sin(num/SINE_POINTS * pi/2), Taylor series in Q30
    function automatic logic [15:0] quarter_sine(logic [63:0] num);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x   = num * HALF_PI_Q30 / SINE_POINTS;
        x2  = (x * x) >> 30;
        t   = x;
        acc = 0;
        for (int i = 0; i < 7; i++)
        begin
            if (i % 2 == 1)
                acc = acc - $signed(t);
            else
                acc = acc + $signed(t);
            t = series_div((t * x2) >> 30, i);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32767)
            acc = 64'sd32767;
        return acc[15:0];
    endfunction

    function automatic logic [15:0] sine_val(int i);
        logic [63:0] q4;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [15:0] v;
        q4   = 64'(4 * i);
        quad = (q4 / SINE_POINTS) % 4;
        rem  = q4 % SINE_POINTS;
        v    = quarter_sine(quad[0] ? 64'(SINE_POINTS) - rem : rem);
        return (quad >= 2) ? 16'(-v) : v;
    endfunction

    logic signed [15:0] rom_w [SINE_POINTS+1];

    for (genvar gi = 0; gi <= SINE_POINTS; gi++)
    begin : g_rom
        localparam logic [15:0] V = sine_val(gi);
        assign rom_w[gi] = V;
    end

    logic [L:0]         addr_lo;
    logic [L:0]         addr_hi;
    logic signed [15:0] lo_reg;
    logic signed [15:0] hi_reg;

    assign addr_lo = (L+1)'(addr);
    assign addr_hi = addr_lo + (L+1)'(1);

    always_ff @(posedge clk)
    begin
        lo_reg <= rom_w[addr_lo];
        hi_reg <= rom_w[addr_hi];
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

FILE: rtl/ggo_pitch_rom.sv
// 2^x table over one octave, Q2.30, registered read.
// Contents built at elaboration; depends on ggo_pkg.
module ggo_pitch_rom #(
    parameter int PITCH_ROM_POINTS = ggo_pkg::GGO_PITCH_ROM_POINTS
) (
    input  logic                                  clk,
    input  logic [$clog2(PITCH_ROM_POINTS)-1:0]   addr,
    output logic [31:0]                           data
);
    import ggo_pkg::*;

    function automatic logic [63:0] fact_div(logic [63:0] t, int k);
        case (k)
            1:       return t;
            2:       return t / 2;
            3:       return t / 3;
            4:       return t / 4;
            5:       return t / 5;
            6:       return t / 6;
            7:       return t / 7;
            8:       return t / 8;
            9:       return t / 9;
            10:      return t / 10;
            11:      return t / 11;
            default: return t / 12;
        endcase
    endfunction

    // exp(y) series with y = j/N * ln2
    function automatic logic [31:0] pitch_val(int j);
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] acc;
        y   = (((64'(j) << 30) / PITCH_ROM_POINTS) * LN2_Q30) >> 30;
        t   = 64'd1 << 30;
        acc = 0;
        for (int k = 1; k <= 12; k++)
        begin
            acc = acc + t;
            t   = fact_div((t * y) >> 30, k);
        end
        return acc[31:0];
    endfunction

    logic [31:0] rom_w [PITCH_ROM_POINTS];

    for (genvar gj = 0; gj < PITCH_ROM_POINTS; gj++)
    begin : g_rom
        localparam logic [31:0] V = pitch_val(gj);
        assign rom_w[gj] = V;
    end

    logic [31:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

FILE: rtl/granular_grain_oscillator.sv
// Grain-cloud oscillator: one input transfer gives 2^os_shift (max MAX_OVERSAMPLE) results.
// Per sub-step: clock update, a grain launch on clock wrap, a pass over all slots working each
// active grain, then normalise and emit. All arithmetic runs through one shared multiplier.
// Not ready while an item is in work; the last result may wait in the output register.
// Async active-low reset clears control state and grains; ROMs are constant, no clear pass.
`include "granular_grain_oscillator_assert.svh"
module granular_grain_oscillator #(
    parameter int MAX_GRAINS       = ggo_pkg::GGO_MAX_GRAINS,
    parameter int SINE_POINTS      = ggo_pkg::GGO_SINE_POINTS,
    parameter int MAX_OVERSAMPLE   = ggo_pkg::GGO_MAX_OVERSAMPLE,
    parameter int PITCH_ROM_POINTS = ggo_pkg::GGO_PITCH_ROM_POINTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] phase_offset
    input  logic                              s_tuser,   // [0] sync_restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [23:0] grain_sample
    output logic                              m_tlast,
    output logic                              m_tuser,   // [0] fund_wrapped
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ggo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ggo_pkg::*;

    localparam int G_W   = $clog2(MAX_GRAINS);
    localparam int GC_W  = $clog2(MAX_GRAINS + 1);
    localparam int SUB_W = $clog2(MAX_OVERSAMPLE + 1);
    localparam int SIN_L = $clog2(SINE_POINTS);
    localparam int PR_L  = $clog2(PITCH_ROM_POINTS);
    localparam int ACC_W = 28 + G_W;

    function automatic logic [15:0] norm_val(int p);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c * 128'(p) <= NORM_SQ)
                r = c;
        end
        return 16'((r + 128'd1) >> 1);
    endfunction

    logic [15:0] norm_rom [MAX_GRAINS+1];

    for (genvar gp = 0; gp <= MAX_GRAINS; gp++)
    begin : g_norm
        localparam logic [15:0] V = (gp == 0) ? 16'd0 : norm_val(gp);
        assign norm_rom[gp] = V;
    end

    // configuration
    logic [31:0] fpi_reg;
    logic [29:0] win_inc_reg;
    logic [16:0] scatter_reg;
    logic [16:0] density_reg;
    logic [1:0]  os_reg;

    // sequencer and oscillator state
    state_t             state_reg, state_next;
    logic [31:0]        lcg_reg, lcg_next;
    logic [31:0]        gcp_reg, gcp_next;
    logic [31:0]        fp_reg, fp_next;
    logic [31:0]        offset_reg, offset_next;
    logic [G_W-1:0]     slot_reg, slot_next;
    logic [MAX_GRAINS-1:0] active_reg, active_next;
    logic [31:0]        gph_reg [MAX_GRAINS];
    logic [31:0]        gph_next [MAX_GRAINS];
    logic [31:0]        ginc_reg [MAX_GRAINS];
    logic [31:0]        ginc_next [MAX_GRAINS];
    logic [32:0]        gwp_reg [MAX_GRAINS];
    logic [32:0]        gwp_next [MAX_GRAINS];
    logic [15:0]        ggain_reg [MAX_GRAINS];
    logic [15:0]        ggain_next [MAX_GRAINS];
    logic [GC_W-1:0]    pp_reg, pp_next;
    logic [15:0]        norm_reg, norm_next;
    logic [SUB_W-1:0]   sub_reg, sub_next;
    logic [SUB_W-1:0]   n_reg, n_next;
    logic [GC_W-1:0]    g_reg, g_next;
    logic               wrapped_reg, wrapped_next;

    // working registers
    logic [16:0]        ss_reg, ss_next;
    logic               e_hi_reg, e_hi_next;
    logic [31:0]        inc_reg, inc_next;
    logic [SIN_L-1:0]   sin_addr_reg, sin_addr_next;
    logic [15:0]        fr_reg, fr_next;
    logic [PR_L-1:0]    pitch_addr_reg, pitch_addr_next;
    logic [15:0]        w_reg, w_next;
    logic [31:0]        wg_reg, wg_next;
    logic signed [17:0] sv_reg, sv_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [23:0] out_reg, out_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    // shared datapath
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [15:0]        sin_lo;
    logic signed [15:0]        sin_hi;
    logic [31:0]               pitch_data;

    logic [16:0]        s_clamp;
    logic [16:0]        d_clamp;
    logic [22:0]        pmul;
    logic [GC_W-1:0]    pp_val;
    logic [3:0]         pow_os;
    logic [SUB_W-1:0]   n_val;
    logic [G_W-1:0]     gi;
    logic [39:0]        clk_sum;
    logic [39:0]        clk_sub;
    logic [32:0]        fund_sum;
    logic [31:0]        wp_sum;
    logic [31:0]        ph_sum;
    logic [47:0]        e_val;
    logic [33:0]        inc_full;
    logic [33:0]        inc_adj;
    logic [31:0]        inc_sat;
    logic [31:0]        mag;
    logic [15:0]        gain_val;
    logic signed [16:0] diff;
    logic signed [2*MUL_W-1:0] interp_sh;
    logic signed [17:0] ts;
    logic [15:0]        w_val;
    logic signed [2*MUL_W-1:0] norm_sh;
    logic signed [23:0] out_sat;
    logic [32:0]        wp_new;
    logic               sub_last;

    ggo_mult u_mult (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ggo_sine_rom #(
        .SINE_POINTS (SINE_POINTS)
    ) u_sine (
        .clk  (clk),
        .addr (sin_addr_reg),
        .lo   (sin_lo),
        .hi   (sin_hi)
    );

    ggo_pitch_rom #(
        .PITCH_ROM_POINTS (PITCH_ROM_POINTS)
    ) u_pitch (
        .clk  (clk),
        .addr (pitch_addr_reg),
        .data (pitch_data)
    );

    assign s_clamp  = (scatter_reg > 17'd65536) ? 17'd65536 : scatter_reg;
    assign d_clamp  = (density_reg > 17'd65536) ? 17'd65536 : density_reg;
    assign pmul     = 23'(d_clamp) * 23'(MAX_GRAINS - 1) + 23'd32768;
    assign pp_val   = GC_W'(pmul[22:16]) + GC_W'(1);
    assign pow_os   = 4'd1 << os_reg;
    assign n_val    = (pow_os > 4'(MAX_OVERSAMPLE)) ? SUB_W'(MAX_OVERSAMPLE) : SUB_W'(pow_os);
    assign gi       = g_reg[G_W-1:0];

    assign clk_sum  = {8'd0, gcp_reg} + (40'(mul_p[39:0]) >> os_reg);
    assign clk_sub  = clk_sum - 40'h01_0000_0000;
    assign fund_sum = {1'b0, fp_reg} + 33'(fpi_reg >> os_reg);
    assign wp_sum   = gwp_reg[gi][31:0] + 32'h4000_0000;
    assign ph_sum   = gph_reg[gi] + offset_reg;
    assign wp_new   = gwp_reg[gi] + 33'(win_inc_reg >> os_reg);

    // pitch exponent: bit 47 picks the octave, bits below index the 2^x table
    assign e_val    = mul_p[47:0] + 48'h8000_0000_0000;
    assign inc_full = mul_p[63:30];
    assign inc_adj  = e_hi_reg ? inc_full : (inc_full >> 1);
    assign inc_sat  = (|inc_adj[33:32]) ? 32'hFFFF_FFFF : inc_adj[31:0];
    assign mag      = lcg_reg[31] ? (~lcg_reg + 32'd1) : lcg_reg;
    assign gain_val = 16'(17'd32768 - 17'(mul_p[48:33]));

    assign diff      = 17'(sin_hi) - 17'(sin_lo);
    assign interp_sh = mul_p >>> 16;
    assign ts        = 18'(sin_lo) + 18'(interp_sh);
    assign w_val     = 16'(18'sd32768 - ts);

    assign norm_sh = mul_p >>> 22;
    always_comb
    begin
        if (norm_sh > 66'sd8388607)
            out_sat = 24'sd8388607;
        else if (norm_sh < -66'sd8388608)
            out_sat = -24'sd8388608;
        else
            out_sat = 24'(norm_sh);
    end

    assign sub_last = (sub_reg == n_reg - SUB_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        lcg_next        = lcg_reg;
        gcp_next        = gcp_reg;
        fp_next         = fp_reg;
        offset_next     = offset_reg;
        slot_next       = slot_reg;
        active_next     = active_reg;
        gph_next        = gph_reg;
        ginc_next       = ginc_reg;
        gwp_next        = gwp_reg;
        ggain_next      = ggain_reg;
        pp_next         = pp_reg;
        norm_next       = norm_reg;
        sub_next        = sub_reg;
        n_next          = n_reg;
        g_next          = g_reg;
        wrapped_next    = wrapped_reg;
        ss_next         = ss_reg;
        e_hi_next       = e_hi_reg;
        inc_next        = inc_reg;
        sin_addr_next   = sin_addr_reg;
        fr_next         = fr_reg;
        pitch_addr_next = pitch_addr_reg;
        w_next          = w_reg;
        wg_next         = wg_reg;
        sv_next         = sv_reg;
        acc_next        = acc_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;
        mul_a           = '0;
        mul_b           = '0;

        if (m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    offset_next  = s_tdata;
                    if (s_tuser)
                    begin
                        gcp_next = '0;
                        fp_next  = '0;
                    end
                    pp_next      = pp_val;
                    norm_next    = norm_rom[pp_val];
                    n_next       = n_val;
                    sub_next     = '0;
                    wrapped_next = 1'b0;
                    state_next   = ST_CLK_MUL;
                end
            end
            ST_CLK_MUL:
            begin
                mul_a      = MUL_W'(fpi_reg);
                mul_b      = MUL_W'(pp_reg);
                state_next = ST_CLK_ADD;
            end
            ST_CLK_ADD:
            begin
                if (|clk_sum[39:32])
                begin
                    // overrun beyond a second wrap holds just below one
                    gcp_next   = (|clk_sub[39:32]) ? 32'hFFFF_FFFF : clk_sub[31:0];
                    state_next = ST_LCG1_MUL;
                end
                else
                begin
                    gcp_next   = clk_sum[31:0];
                    state_next = ST_FUND;
                end
            end
            ST_LCG1_MUL:
            begin
                mul_a      = MUL_W'(lcg_reg);
                mul_b      = MUL_W'(LCG_MUL);
                state_next = ST_LCG1_W;
            end
            ST_LCG1_W:
            begin
                lcg_next   = mul_p[31:0] + LCG_ADD;
                state_next = ST_SS_MUL;
            end
            ST_SS_MUL:
            begin
                mul_a      = MUL_W'(s_clamp);
                mul_b      = MUL_W'(s_clamp);
                state_next = ST_SS_W;
            end
            ST_SS_W:
            begin
                ss_next    = mul_p[32:16];
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                mul_a      = MUL_W'($signed(lcg_reg));
                mul_b      = MUL_W'(ss_reg);
                state_next = ST_E_W;
            end
            ST_E_W:
            begin
                e_hi_next       = e_val[47];
                pitch_addr_next = e_val[46 -: PR_L];
                state_next      = ST_PITCH_RD;
            end
            ST_PITCH_RD:
            begin
                state_next = ST_INC_MUL;
            end
            ST_INC_MUL:
            begin
                mul_a      = MUL_W'(fpi_reg);
                mul_b      = MUL_W'(pitch_data);
                state_next = ST_INC_W;
            end
            ST_INC_W:
            begin
                inc_next   = inc_sat;
                state_next = ST_LCG2_MUL;
            end
            ST_LCG2_MUL:
            begin
                mul_a      = MUL_W'(lcg_reg);
                mul_b      = MUL_W'(LCG_MUL);
                state_next = ST_LCG2_W;
            end
            ST_LCG2_W:
            begin
                lcg_next   = mul_p[31:0] + LCG_ADD;
                state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL:
            begin
                mul_a      = MUL_W'(s_clamp);
                mul_b      = MUL_W'(mag);
                state_next = ST_GAIN_W;
            end
            ST_GAIN_W:
            begin
                // launch overwrites the slot even if its grain is still running
                active_next[slot_reg] = 1'b1;
                gph_next[slot_reg]    = '0;
                ginc_next[slot_reg]   = inc_reg;
                gwp_next[slot_reg]    = '0;
                ggain_next[slot_reg]  = gain_val;
                slot_next  = (slot_reg == G_W'(MAX_GRAINS - 1)) ? '0 : slot_reg + G_W'(1);
                state_next = ST_FUND;
            end
            ST_FUND:
            begin
                fp_next      = fund_sum[31:0];
                wrapped_next = wrapped_reg | fund_sum[32];
                g_next       = '0;
                acc_next     = '0;
                state_next   = ST_GRAIN;
            end
            ST_GRAIN:
            begin
                if (g_reg == GC_W'(MAX_GRAINS))
                    state_next = ST_NORM_MUL;
                else if (active_reg[gi])
                begin
                    // window weight reads sine at pos + 1/4
                    sin_addr_next = wp_sum[31 -: SIN_L];
                    fr_next       = wp_sum[31-SIN_L -: 16];
                    state_next    = ST_WIN_RD;
                end
                else
                    g_next = g_reg + GC_W'(1);
            end
            ST_WIN_RD:
            begin
                state_next = ST_WIN_MUL;
            end
            ST_WIN_MUL:
            begin
                mul_a      = MUL_W'(diff);
                mul_b      = MUL_W'(fr_reg);
                state_next = ST_WIN_W;
            end
            ST_WIN_W:
            begin
                w_next        = w_val;
                sin_addr_next = ph_sum[31 -: SIN_L];
                fr_next       = ph_sum[31-SIN_L -: 16];
                state_next    = ST_WG_MUL;
            end
            ST_WG_MUL:
            begin
                mul_a      = MUL_W'(w_reg);
                mul_b      = MUL_W'(ggain_reg[gi]);
                state_next = ST_WG_W;
            end
            ST_WG_W:
            begin
                wg_next    = mul_p[31:0];
                state_next = ST_SIN_MUL;
            end
            ST_SIN_MUL:
            begin
                mul_a      = MUL_W'(diff);
                mul_b      = MUL_W'(fr_reg);
                state_next = ST_SIN_W;
            end
            ST_SIN_W:
            begin
                sv_next    = ts;
                state_next = ST_TERM_MUL;
            end
            ST_TERM_MUL:
            begin
                mul_a      = MUL_W'(sv_reg);
                mul_b      = MUL_W'(wg_reg);
                state_next = ST_TERM_W;
            end
            ST_TERM_W:
            begin
                acc_next     = acc_reg + ACC_W'(mul_p >>> 20);
                gph_next[gi] = gph_reg[gi] + (ginc_reg[gi] >> os_reg);
                gwp_next[gi] = wp_new;
                if (wp_new[32])
                    active_next[gi] = 1'b0;
                g_next     = g_reg + GC_W'(1);
                state_next = ST_GRAIN;
            end
            ST_NORM_MUL:
            begin
                mul_a      = MUL_W'(acc_reg);
                mul_b      = MUL_W'(norm_reg);
                state_next = ST_NORM_W;
            end
            ST_NORM_W:
            begin
                out_next   = out_sat;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = out_reg;
                    m_tlast_next  = sub_last;
                    m_tuser_next  = sub_last & wrapped_reg;
                    sub_next      = sub_reg + SUB_W'(1);
                    state_next    = sub_last ? ST_IDLE : ST_CLK_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lcg_reg      <= LCG_SEED;
            gcp_reg      <= '0;
            fp_reg       <= '0;
            slot_reg     <= '0;
            active_reg   <= '0;
            sub_reg      <= '0;
            n_reg        <= SUB_W'(1);
            g_reg        <= '0;
            wrapped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lcg_reg      <= lcg_next;
            gcp_reg      <= gcp_next;
            fp_reg       <= fp_next;
            slot_reg     <= slot_next;
            active_reg   <= active_next;
            sub_reg      <= sub_next;
            n_reg        <= n_next;
            g_reg        <= g_next;
            wrapped_reg  <= wrapped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg     <= offset_next;
        gph_reg        <= gph_next;
        ginc_reg       <= ginc_next;
        gwp_reg        <= gwp_next;
        ggain_reg      <= ggain_next;
        pp_reg         <= pp_next;
        norm_reg       <= norm_next;
        ss_reg         <= ss_next;
        e_hi_reg       <= e_hi_next;
        inc_reg        <= inc_next;
        sin_addr_reg   <= sin_addr_next;
        fr_reg         <= fr_next;
        pitch_addr_reg <= pitch_addr_next;
        w_reg          <= w_next;
        wg_reg         <= wg_next;
        sv_reg         <= sv_next;
        acc_reg        <= acc_next;
        out_reg        <= out_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpi_reg     <= '0;
            win_inc_reg <= 30'd16777216;
            scatter_reg <= '0;
            density_reg <= '0;
            os_reg      <= 2'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FUND_INC: fpi_reg     <= cfg_data;
                CFG_WIN_INC:  win_inc_reg <= cfg_data[29:0];
                CFG_SCATTER:  scatter_reg <= cfg_data[16:0];
                CFG_DENSITY:  density_reg <= cfg_data[16:0];
                CFG_OS_SHIFT: os_reg      <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    `GGO_ASSERT(a_busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)
    `GGO_ASSERT(a_wrap_only_on_last, clk, rst_n, (m_tvalid && m_tuser) |-> m_tlast)
    `GGO_ASSERT(a_sub_in_range, clk, rst_n, (state_reg != ST_IDLE) |-> (sub_reg < n_reg))
    `GGO_ASSERT(a_grain_idx, clk, rst_n, g_reg <= GC_W'(MAX_GRAINS))
    `GGO_ASSERT_NR(a_reset_idle, clk, (!rst_n) |=> (s_tready && !m_tvalid))

endmodule
